// ===== design/tbaor_pkg.sv =====
// Shared constants, types and state codes for the tilt block averager.
package tbaor_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int TILT_W     = 14;
  localparam int AXES       = 3;
  localparam int ROW_W      = AXES * SAMPLE_W;
  localparam int CFG_ADDR_W = 2;
  localparam int BLK_W      = 2;

  localparam int BLOCK_LEN_DEF   = 20;
  localparam int TOTAL_SLOTS_DEF = 60;

  localparam logic [BLK_W-1:0] LAST_BLOCK = 2'd2;

  localparam logic [SAMPLE_W-1:0] CLAMP_LOW_RST   = 12'd1229;
  localparam logic [SAMPLE_W-1:0] CLAMP_HIGH_RST  = 12'd2867;
  localparam logic [SAMPLE_W-1:0] ZERO_OFFSET_RST = 12'd2048;
  localparam logic [SAMPLE_W-1:0] HELD_RST        = 12'd2048;

  // Tilt scale: (held - offset) * 100 / 91
  localparam int TILT_MUL = 100;
  localparam int TILT_DIV = 91;

  // Tilt scale as one multiply: floor(m * TILT_RCP / 2^TILT_SHIFT) equals
  // floor(m * 100 / 91) for every 12-bit magnitude m
  localparam int     TILT_SHIFT = 26;
  localparam longint TILT_RCP   = longint'(TILT_MUL) *
                                  (((longint'(1) << TILT_SHIFT) + TILT_DIV - 1) / TILT_DIV);

  // Block mean divide by BLOCK_LEN as a reciprocal multiply, default sizing
  localparam int     DIV_W_DEF    = $clog2(BLOCK_LEN_DEF * ((1 << SAMPLE_W) - 1) + 1);
  localparam int     MEAN_S_DEF   = DIV_W_DEF + $clog2(BLOCK_LEN_DEF);
  localparam longint MEAN_RCP_DEF = ((longint'(1) << MEAN_S_DEF) + BLOCK_LEN_DEF - 1) /
                                    BLOCK_LEN_DEF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CLAMP_LOW   = 2'd0,
    CFG_CLAMP_HIGH  = 2'd1,
    CFG_ZERO_OFFSET = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_SWEEP,
    S_MEAN,
    S_MEANW,
    S_REJ,
    S_TILT,
    S_TILTW,
    S_OUT
  } st_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/tbaor_in_if.sv =====
// Input sample request channel: three raw axis samples with ready flags.
interface tbaor_in_if;
  import tbaor_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] x_sample;
  logic [SAMPLE_W-1:0] y_sample;
  logic [SAMPLE_W-1:0] z_sample;
  logic                x_ready;
  logic                y_ready;
  logic                z_ready;

  modport source (
    output valid, x_sample, y_sample, z_sample, x_ready, y_ready, z_ready,
    input  ready
  );
  modport sink (
    input  valid, x_sample, y_sample, z_sample, x_ready, y_ready, z_ready,
    output ready
  );
endinterface

// ===== design/tbaor_out_if.sv =====
// Result request channel: signed tilt per axis.
interface tbaor_out_if;
  import tbaor_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TILT_W-1:0] x_tilt;
  logic signed [TILT_W-1:0] y_tilt;
  logic signed [TILT_W-1:0] z_tilt;

  modport source (
    output valid, x_tilt, y_tilt, z_tilt,
    input  ready
  );
  modport sink (
    input  valid, x_tilt, y_tilt, z_tilt,
    output ready
  );
endinterface

// ===== design/tbaor_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface tbaor_cfg_if;
  import tbaor_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [SAMPLE_W-1:0]   data;

  modport source (
    output valid, addr, data,
    input  ready
  );
  modport sink (
    input  valid, addr, data,
    output ready
  );
endinterface

// ===== design/tilt_block_average_outlier_reject.sv =====
// Tilt sensor block averager with outlier rejection: top level.
//
// Usage: each request on in_ch carries one raw 12-bit sample per axis and a
// ready flag per axis. A ready sample replaces the current slot of the
// circular sample store, a not-ready one keeps it; the slot is then clamped
// to clamp_high and clamp_low. Each full block of BLOCK_LEN slots leaves a
// per-axis block mean; at the end of the store each axis drops the block
// mean farthest from its held value and holds the mean of the other two.
// Every request yields one result on out_ch: (held - zero_offset)*100/91,
// truncated toward zero. cfg_ch writes clamp_low, clamp_high, zero_offset
// (index 0, 1, 2) and is always ready; write it only while the block idles.
// Timing: one request at a time. A plain request writes its row, then runs
// the tilt scale, a reciprocal multiply that latches the operands and then
// registers the products. A request that closes a block first reads the
// block's rows from the store (one row per cycle on the single read port)
// and scales their sum into the block mean; the end of the store adds the
// outlier rejection step.
// Reset clears the store, the means and the counter and sets the held value
// to 2048. A stalled receiver holds the result register; the block then
// takes the next request and finishes it up to the output register.
module tilt_block_average_outlier_reject #(
  parameter int BLOCK_LEN   = tbaor_pkg::BLOCK_LEN_DEF,
  parameter int TOTAL_SLOTS = tbaor_pkg::TOTAL_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbaor_in_if.sink    in_ch,
  tbaor_out_if.source out_ch,
  tbaor_cfg_if.sink   cfg_ch
);
  import tbaor_pkg::*;

  localparam int ADDR_W  = $clog2(TOTAL_SLOTS);
  localparam int SPAN    = (3 * BLOCK_LEN > TOTAL_SLOTS) ? 3 * BLOCK_LEN : TOTAL_SLOTS;
  localparam int IDX_W   = $clog2(SPAN + 1);
  localparam int SUM_W   = $clog2(BLOCK_LEN * ((1 << SAMPLE_W) - 1) + 1);
  localparam int DIV_W   = (SUM_W > SAMPLE_W) ? SUM_W : SAMPLE_W;
  localparam int MEAN_S  = DIV_W + $clog2(BLOCK_LEN);
  localparam longint MEAN_RCP = ((longint'(1) << MEAN_S) + BLOCK_LEN - 1) / BLOCK_LEN;

  // Abs difference of two raw codes
  function automatic logic [SAMPLE_W-1:0] gap(input logic [SAMPLE_W-1:0] a,
                                             input logic [SAMPLE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Drop the block mean farthest from the held value, average the others
  function automatic logic [SAMPLE_W-1:0] pick_mean(input logic [SAMPLE_W-1:0] h,
                                                   input logic [SAMPLE_W-1:0] m0,
                                                   input logic [SAMPLE_W-1:0] m1,
                                                   input logic [SAMPLE_W-1:0] m2);
    logic [SAMPLE_W-1:0] g0;
    logic [SAMPLE_W-1:0] g1;
    logic [SAMPLE_W-1:0] g2;
    logic [SAMPLE_W:0]   s;
    g0 = gap(h, m0);
    g1 = gap(h, m1);
    g2 = gap(h, m2);
    if (g0 > g1) begin
      s = (g0 > g2) ? ({1'b0, m1} + {1'b0, m2}) : ({1'b0, m0} + {1'b0, m1});
    end else begin
      s = (g1 > g2) ? ({1'b0, m0} + {1'b0, m2}) : ({1'b0, m0} + {1'b0, m1});
    end
    return s[SAMPLE_W:1];
  endfunction

  st_e state_q, state_d;

  // Configuration
  logic [SAMPLE_W-1:0] clamp_lo_q, clamp_hi_q, zero_off_q;

  // Slot position
  logic [ADDR_W-1:0] slot_q;
  logic [IDX_W-1:0]  pos_q;
  logic [BLK_W-1:0]  blk_q;
  logic [BLK_W-1:0]  blk_cur_q;
  logic              store_end_q;
  logic              blk_end, store_end;

  // Latched request
  logic [SAMPLE_W-1:0] smp_q [AXES];
  logic [AXES-1:0]     rdy_q;

  // Block means and held values
  logic [SAMPLE_W-1:0] mean_q [AXES][3];
  logic [SAMPLE_W-1:0] held_q [AXES];

  // Sweep
  logic [IDX_W-1:0] k_q;
  logic             inr_q;
  logic [SUM_W-1:0] sum_q [AXES];
  logic [IDX_W-1:0] first, sa;
  logic             sa_in;

  // Memory port
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_row, wr_row;

  // Divider
  logic             div_start;
  logic             div_mean;
  logic [DIV_W-1:0] div_dvd [AXES];
  logic [DIV_W-1:0] div_quo [AXES];
  div_stat_t        div_stat;

  // Tilt
  logic [SAMPLE_W-1:0]      mag [AXES];
  logic [AXES-1:0]          neg, neg_q;
  logic                     load_out;
  logic                     out_valid_q;
  logic signed [TILT_W-1:0] tilt_q [AXES];
  logic signed [TILT_W-1:0] tilt_d [AXES];

  logic in_acc;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign blk_end   = (pos_q == IDX_W'(BLOCK_LEN - 1));
  assign store_end = (slot_q == ADDR_W'(TOTAL_SLOTS - 1));
  assign first     = IDX_W'(blk_cur_q) * IDX_W'(BLOCK_LEN);
  assign sa        = first + k_q;
  assign sa_in     = (k_q < IDX_W'(BLOCK_LEN)) && (sa < IDX_W'(TOTAL_SLOTS));

  // Merge ready samples into the old row and clamp each slot
  always_comb begin
    logic [SAMPLE_W-1:0] v;
    for (int a = 0; a < AXES; a++) begin
      v = rdy_q[a] ? smp_q[a] : rd_row[a*SAMPLE_W +: SAMPLE_W];
      if (v > clamp_hi_q) v = clamp_hi_q;
      if (v < clamp_lo_q) v = clamp_lo_q;
      wr_row[a*SAMPLE_W +: SAMPLE_W] = v;
    end
  end

  // Split offset-corrected held values into sign and magnitude
  always_comb begin
    logic signed [SAMPLE_W:0] d;
    logic [SAMPLE_W:0]        m;
    for (int a = 0; a < AXES; a++) begin
      d      = signed'({1'b0, held_q[a]}) - signed'({1'b0, zero_off_q});
      neg[a] = d[SAMPLE_W];
      m      = neg[a] ? unsigned'(-d) : unsigned'(d);
      mag[a] = m[SAMPLE_W-1:0];
    end
  end

  // Restore the sign of the scaled magnitude
  always_comb begin
    logic [TILT_W-1:0] tq;
    for (int a = 0; a < AXES; a++) begin
      tq        = div_quo[a][TILT_W-1:0];
      tilt_d[a] = neg_q[a] ? signed'(-tq) : signed'(tq);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MOD;
      S_MOD: begin
        if (blk_end) begin
          state_d = S_SWEEP;
        end else if (store_end) begin
          state_d = S_REJ;
        end else begin
          state_d = S_TILT;
        end
      end
      S_SWEEP: if (k_q == IDX_W'(BLOCK_LEN)) state_d = S_MEAN;
      S_MEAN:  state_d = S_MEANW;
      S_MEANW: if (div_stat.done) state_d = store_end_q ? S_REJ : S_TILT;
      S_REJ:   state_d = S_TILT;
      S_TILT:  state_d = S_TILTW;
      S_TILTW: if (div_stat.done) state_d = S_OUT;
      S_OUT:   if (!out_valid_q || out_ch.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = slot_q;
    wr_en     = 1'b0;
    div_start = 1'b0;
    div_mean  = 1'b0;
    load_out  = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      div_dvd[a] = DIV_W'(mag[a]);
    end
    unique case (state_q)
      S_IDLE: rd_en = in_acc;
      S_MOD:  wr_en = 1'b1;
      S_SWEEP: begin
        rd_en   = sa_in;
        rd_addr = sa[ADDR_W-1:0];
      end
      S_MEAN: begin
        div_start = 1'b1;
        div_mean  = 1'b1;
        for (int a = 0; a < AXES; a++) begin
          div_dvd[a] = DIV_W'(sum_q[a]);
        end
      end
      S_TILT:  div_start = 1'b1;
      S_OUT:   load_out = !out_valid_q || out_ch.ready;
      default: ;
    endcase
  end

  // State, configuration, counters and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clamp_lo_q  <= CLAMP_LOW_RST;
      clamp_hi_q  <= CLAMP_HIGH_RST;
      zero_off_q  <= ZERO_OFFSET_RST;
      slot_q      <= '0;
      pos_q       <= '0;
      blk_q       <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        held_q[a] <= HELD_RST;
        for (int b = 0; b < 3; b++) begin
          mean_q[a][b] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_ch.valid) begin
        unique case (cfg_reg_e'(cfg_ch.addr))
          CFG_CLAMP_LOW:   clamp_lo_q <= cfg_ch.data;
          CFG_CLAMP_HIGH:  clamp_hi_q <= cfg_ch.data;
          CFG_ZERO_OFFSET: zero_off_q <= cfg_ch.data;
          default: ;
        endcase
      end
      // Advance the slot position once the row is written
      if (state_q == S_MOD) begin
        if (store_end) begin
          slot_q <= '0;
          pos_q  <= '0;
          blk_q  <= '0;
        end else begin
          slot_q <= slot_q + 1'b1;
          if (blk_end && blk_q != LAST_BLOCK) begin
            pos_q <= '0;
            blk_q <= blk_q + 1'b1;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
      end
      if (state_q == S_MEANW && div_stat.done) begin
        for (int a = 0; a < AXES; a++) begin
          mean_q[a][blk_cur_q] <= div_quo[a][SAMPLE_W-1:0];
        end
      end
      if (state_q == S_REJ) begin
        for (int a = 0; a < AXES; a++) begin
          held_q[a] <= pick_mean(held_q[a], mean_q[a][0], mean_q[a][1], mean_q[a][2]);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request payload, sweep accumulation and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q[0] <= in_ch.x_sample;
      smp_q[1] <= in_ch.y_sample;
      smp_q[2] <= in_ch.z_sample;
      rdy_q    <= {in_ch.z_ready, in_ch.y_ready, in_ch.x_ready};
    end
    if (state_q == S_MOD) begin
      blk_cur_q   <= blk_q;
      store_end_q <= store_end;
      k_q         <= '0;
      inr_q       <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
      end
    end
    if (state_q == S_SWEEP) begin
      k_q   <= k_q + 1'b1;
      inr_q <= sa_in;
      if (inr_q) begin
        for (int a = 0; a < AXES; a++) begin
          sum_q[a] <= sum_q[a] + SUM_W'(rd_row[a*SAMPLE_W +: SAMPLE_W]);
        end
      end
    end
    if (state_q == S_TILT) begin
      neg_q <= neg;
    end
    if (load_out) begin
      for (int a = 0; a < AXES; a++) begin
        tilt_q[a] <= tilt_d[a];
      end
    end
  end

  tbaor_sample_ram #(
    .DEPTH (TOTAL_SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot_q),
    .wr_data_i (wr_row),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_row)
  );

  tbaor_div #(
    .DIV_W    (DIV_W),
    .MEAN_S   (MEAN_S),
    .MEAN_RCP (MEAN_RCP)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .mean_i     (div_mean),
    .dividend_i (div_dvd),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  assign in_ch.ready   = (state_q == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_q;
  assign out_ch.x_tilt = tilt_q[0];
  assign out_ch.y_tilt = tilt_q[1];
  assign out_ch.z_tilt = tilt_q[2];

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_MEANW || state_q == S_TILTW))
    else $error("divider finished outside a wait state");

  a_slot_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && store_end) |=> (slot_q == '0 && blk_q == '0))
    else $error("slot position did not wrap at the end of the store");

  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && rd_en) |-> (rd_addr <= ADDR_W'(TOTAL_SLOTS - 1)))
    else $error("sweep read past the sample store");

  a_accept_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MOD))
    else $error("accepted request did not reach the row update");
`endif

endmodule

// ===== design/tbaor_sample_ram.sv =====
// Sample store: one row of three axis slots per entry, registered read, row valid bits.
module tbaor_sample_ram #(
  parameter int DEPTH = tbaor_pkg::TOTAL_SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [tbaor_pkg::ROW_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output logic [tbaor_pkg::ROW_W-1:0] rd_data_o
);
  import tbaor_pkg::*;

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [ROW_W-1:0] rdata_q;
  logic             rvld_q;

  // Write the array; the read data is registered
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Track written rows; an unwritten row reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

// ===== design/tbaor_div.sv =====
// Three-lane constant divider: reciprocal multiply for the block mean and the tilt scale.
module tbaor_div #(
  parameter int     DIV_W    = tbaor_pkg::DIV_W_DEF,
  parameter int     MEAN_S   = tbaor_pkg::MEAN_S_DEF,
  parameter longint MEAN_RCP = tbaor_pkg::MEAN_RCP_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  mean_i,
  input  logic [DIV_W-1:0]      dividend_i [tbaor_pkg::AXES],
  output logic [DIV_W-1:0]      quotient_o [tbaor_pkg::AXES],
  output tbaor_pkg::div_stat_t  stat_o
);
  import tbaor_pkg::*;

  localparam longint RCP_MAX = (MEAN_RCP > TILT_RCP) ? MEAN_RCP : TILT_RCP;
  localparam int     RCP_W   = $clog2(RCP_MAX + 1);
  localparam int     PRD_W   = DIV_W + RCP_W;

  logic             busy_q;
  logic             done_q;
  logic             mean_q;
  logic [DIV_W-1:0] dvd_q [AXES];
  logic [PRD_W-1:0] prd_q [AXES];

  // Step the sequence: operands in, products registered, done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  // Latch operands, then multiply by the reciprocal of the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mean_q <= mean_i;
      for (int l = 0; l < AXES; l++) begin
        dvd_q[l] <= dividend_i[l];
      end
    end
    if (busy_q) begin
      for (int l = 0; l < AXES; l++) begin
        prd_q[l] <= mean_q ? PRD_W'(dvd_q[l]) * PRD_W'(MEAN_RCP)
                           : PRD_W'(dvd_q[l]) * PRD_W'(TILT_RCP);
      end
    end
  end

  // Drop the fraction bits
  always_comb begin
    for (int l = 0; l < AXES; l++) begin
      quotient_o[l] = mean_q ? DIV_W'(prd_q[l] >> MEAN_S) : DIV_W'(prd_q[l] >> TILT_SHIFT);
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the tilt block averager with outlier rejection.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tbaor_pkg::*;

  typedef struct packed {
    logic [AXES-1:0]               rdy;
    logic [AXES-1:0][SAMPLE_W-1:0] smp;
  } sample_set_t;

  typedef logic [AXES-1:0][TILT_W-1:0] tilt_set_t;

  localparam int MAX_CODE = (1 << SAMPLE_W) - 1;

  logic clk_i = 1'b0;
  logic rst_ni;

  tbaor_in_if  in_ch ();
  tbaor_out_if out_ch ();
  tbaor_cfg_if cfg_ch ();

  tilt_block_average_outlier_reject uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state and register copies
  logic [SAMPLE_W-1:0] raw_store [AXES][TOTAL_SLOTS_DEF];
  logic [SAMPLE_W-1:0] blk_mean  [AXES][3];
  logic [SAMPLE_W-1:0] held_code [AXES];
  int unsigned         slot_ctr;
  logic [SAMPLE_W-1:0] clamp_lo, clamp_hi, zero_ofs;

  tilt_set_t tilt_q[$];
  int        err_cnt = 0;
  int        tx_gap_max = 10;
  int        rx_stall_max = 10;

  // Block offsets per pattern that force each tie branch of the rejection
  int tie_pat [6][3] = '{'{1, -1, 0}, '{0, 0, 0}, '{1, 0, 1},
                         '{2, 0, 1}, '{0, 1, 0}, '{0, 1, 1}};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] clip_code(input int v);
    if (v < 0) return '0;
    if (v > MAX_CODE) return MAX_CODE[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic sample_set_t mk_set(input logic [2:0] rdy, input int x, input int y,
                                         input int z);
    sample_set_t s;
    s.rdy = rdy;
    s.smp[0] = clip_code(x);
    s.smp[1] = clip_code(y);
    s.smp[2] = clip_code(z);
    return s;
  endfunction

  function automatic int abs_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advance the predictor by one accepted request and queue its tilt
  task automatic predict_tilt(input sample_set_t s);
    int cnt, blk, sum, idx, m0, m1, m2, h, g0, g1, g2, r, d, t;
    logic [SAMPLE_W-1:0] v;
    tilt_set_t res;
    cnt = slot_ctr % TOTAL_SLOTS_DEF;
    blk = cnt / BLOCK_LEN_DEF;
    for (int a = 0; a < AXES; a++) begin
      if (s.rdy[a]) raw_store[a][cnt] = s.smp[a];
      v = raw_store[a][cnt];
      if (v > clamp_hi) v = clamp_hi;
      if (v < clamp_lo) v = clamp_lo;
      raw_store[a][cnt] = v;
    end
    if (blk > int'(LAST_BLOCK)) blk = int'(LAST_BLOCK);
    // Block end: store the truncated mean per axis
    if (cnt == blk * BLOCK_LEN_DEF + BLOCK_LEN_DEF - 1) begin
      for (int a = 0; a < AXES; a++) begin
        sum = 0;
        for (int k = 0; k < BLOCK_LEN_DEF; k++) begin
          idx = blk * BLOCK_LEN_DEF + k;
          if (idx < TOTAL_SLOTS_DEF) sum += int'(raw_store[a][idx]);
        end
        blk_mean[a][blk] = clip_code(sum / BLOCK_LEN_DEF);
      end
    end
    // Store end: drop the mean farthest from the held value
    if (cnt == TOTAL_SLOTS_DEF - 1) begin
      for (int a = 0; a < AXES; a++) begin
        h  = int'(held_code[a]);
        m0 = int'(blk_mean[a][0]);
        m1 = int'(blk_mean[a][1]);
        m2 = int'(blk_mean[a][2]);
        g0 = abs_gap(h, m0);
        g1 = abs_gap(h, m1);
        g2 = abs_gap(h, m2);
        if (g0 > g1) r = (g0 > g2) ? (m1 + m2) / 2 : (m0 + m1) / 2;
        else         r = (g1 > g2) ? (m0 + m2) / 2 : (m0 + m1) / 2;
        held_code[a] = clip_code(r);
      end
    end
    slot_ctr = cnt + 1;
    for (int a = 0; a < AXES; a++) begin
      d = int'(held_code[a]) - int'(zero_ofs);
      t = (d * TILT_MUL) / TILT_DIV;
      res[a] = t[TILT_W-1:0];
    end
    tilt_q.push_back(res);
  endtask

  // Send one sample request after a random gap
  task automatic send_sample(input sample_set_t s);
    int n;
    n = $urandom_range(0, tx_gap_max);
    @(negedge clk_i);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.x_sample <= s.smp[0];
    in_ch.y_sample <= s.smp[1];
    in_ch.z_sample <= s.smp[2];
    in_ch.x_ready  <= s.rdy[0];
    in_ch.y_ready  <= s.rdy[1];
    in_ch.z_ready  <= s.rdy[2];
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predict_tilt(s);
  endtask

  // Drop valid, then hold until every expected tilt has come back
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (tilt_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int val);
    drain();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val[SAMPLE_W-1:0];
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_CLAMP_LOW:   clamp_lo = val[SAMPLE_W-1:0];
      CFG_CLAMP_HIGH:  clamp_hi = val[SAMPLE_W-1:0];
      CFG_ZERO_OFFSET: zero_ofs = val[SAMPLE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(input int lo, input int hi, input int ofs);
    write_reg(CFG_CLAMP_LOW, lo);
    write_reg(CFG_CLAMP_HIGH, hi);
    write_reg(CFG_ZERO_OFFSET, ofs);
  endtask

  // Not-ready slots after reset, field extremes under default limits
  task automatic test_reset_state();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    send_sample(mk_set(3'b000, $urandom_range(0, MAX_CODE), 0, MAX_CODE));
    send_sample(mk_set(3'b000, 0, 0, 0));
    send_sample(mk_set(3'b111, 0, 0, 0));
    send_sample(mk_set(3'b111, MAX_CODE, MAX_CODE, MAX_CODE));
    send_sample(mk_set(3'b101, 'hAAA, 'h555, 'hFFF));
    send_sample(mk_set(3'b010, 'h555, 'hAAA, 0));
    send_sample(mk_set(3'b111, 2000, 1229, 2867));
  endtask

  // Full-range limits, offset extremes and crossed clamp limits
  task automatic test_clamp_limits();
    tx_gap_max   = 10;
    rx_stall_max = 10;
    set_regs(0, MAX_CODE, 0);
    send_sample(mk_set(3'b111, 0, MAX_CODE, 2048));
    send_sample(mk_set(3'b000, 1, 2, 3));
    write_reg(CFG_ZERO_OFFSET, MAX_CODE);
    send_sample(mk_set(3'b011, MAX_CODE, 0, 1));
    set_regs(3000, 1000, 2048);
    send_sample(mk_set(3'b111, 2000, 0, MAX_CODE));
    send_sample(mk_set(3'b000, 0, 0, 0));
    set_regs(MAX_CODE, 0, 100);
    send_sample(mk_set(3'b111, 0, MAX_CODE, 100));
    send_sample(mk_set(3'b110, 5, 6, 7));
  endtask

  // Constant blocks around the held value so that gaps tie on purpose
  task automatic test_reject_ties();
    int pat[AXES];
    int step[AXES];
    int blk;
    int v[AXES];
    set_regs(0, MAX_CODE, 2048);
    while (slot_ctr % TOTAL_SLOTS_DEF != 0)
      send_sample(mk_set(3'($urandom), $urandom, $urandom, $urandom));
    for (int rnd = 0; rnd < 3; rnd++) begin
      for (int a = 0; a < AXES; a++) begin
        pat[a]  = $urandom_range(0, 5);
        step[a] = $urandom_range(1, 200) * ($urandom_range(0, 1) ? 1 : -1);
      end
      for (int i = 0; i < TOTAL_SLOTS_DEF; i++) begin
        blk = (slot_ctr % TOTAL_SLOTS_DEF) / BLOCK_LEN_DEF;
        for (int a = 0; a < AXES; a++)
          v[a] = int'(held_code[a]) + tie_pat[pat[a]][blk] * step[a];
        send_sample(mk_set(3'b111, v[0], v[1], v[2]));
      end
    end
  endtask

  // Clustered rounds with one outlier block per axis, plus noise
  task automatic test_random_rounds();
    int lims [6][3] = '{'{1229, 2867, 2048}, '{0, 4095, 0}, '{0, 4095, 4095},
                        '{3000, 1000, 1500}, '{1000, 1100, 2048}, '{0, 4095, 2048}};
    int center[AXES];
    int shift[AXES];
    int outlier[AXES];
    int blk;
    int v[AXES];
    logic [2:0] rdy;
    for (int p = 0; p < 6; p++) begin
      set_regs(lims[p][0], lims[p][1], (p == 5) ? $urandom_range(0, MAX_CODE) : lims[p][2]);
      tx_gap_max   = (p % 3 == 2) ? 0 : 10;
      rx_stall_max = (p % 3 == 2) ? 0 : 10;
      for (int i = 0; i < 75; i++) begin
        if (i == 0 || slot_ctr % TOTAL_SLOTS_DEF == 0) begin
          for (int a = 0; a < AXES; a++) begin
            center[a]  = $urandom_range(0, MAX_CODE);
            shift[a]   = $urandom_range(200, 1500) * ($urandom_range(0, 1) ? 1 : -1);
            outlier[a] = $urandom_range(0, 2);
          end
        end
        // Hold off once mid-phase until the block has caught up
        if (p == 1 && i == 40) drain();
        blk = (slot_ctr % TOTAL_SLOTS_DEF) / BLOCK_LEN_DEF;
        if ($urandom_range(0, 99) < 85) begin
          for (int a = 0; a < AXES; a++) begin
            v[a] = center[a] + ((blk == outlier[a]) ? shift[a] : 0)
                   + $urandom_range(0, 96) - 48;
            rdy[a] = ($urandom_range(0, 9) != 0);
          end
        end else begin
          for (int a = 0; a < AXES; a++) v[a] = $urandom_range(0, MAX_CODE);
          rdy = 3'($urandom);
        end
        send_sample(mk_set(rdy, v[0], v[1], v[2]));
      end
    end
  endtask

  // Result checker with random receiver stalls
  initial begin : tilt_check
    int n;
    tilt_set_t want;
    tilt_set_t got;
    string axis_name [AXES] = '{"x", "y", "z"};
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      n = $urandom_range(0, rx_stall_max);
      @(negedge clk_i);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      got[0] = out_ch.x_tilt;
      got[1] = out_ch.y_tilt;
      got[2] = out_ch.z_tilt;
      if (tilt_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]));
        err_cnt++;
      end else begin
        want = tilt_q.pop_front();
        for (int a = 0; a < AXES; a++) begin
          if (got[a] !== want[a]) begin
            $display("%0t: %s_tilt mismatch expected %0d actual %0d", $time,
                     axis_name[a], $signed(want[a]), $signed(got[a]));
            err_cnt++;
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.x_sample = '0;
    in_ch.y_sample = '0;
    in_ch.z_sample = '0;
    in_ch.x_ready  = 1'b0;
    in_ch.y_ready  = 1'b0;
    in_ch.z_ready  = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.addr    = CFG_CLAMP_LOW;
    cfg_ch.data    = '0;
    for (int a = 0; a < AXES; a++) begin
      for (int i = 0; i < TOTAL_SLOTS_DEF; i++) raw_store[a][i] = '0;
      for (int b = 0; b < 3; b++) blk_mean[a][b] = '0;
      held_code[a] = HELD_RST;
    end
    slot_ctr = 0;
    clamp_lo = CLAMP_LOW_RST;
    clamp_hi = CLAMP_HIGH_RST;
    zero_ofs = ZERO_OFFSET_RST;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_clamp_limits();
    test_reject_ties();
    test_random_rounds();

    drain();
    repeat (100) @(posedge clk_i);
    if (tilt_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tilt_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
